// ----- design/bchd_pkg.sv -----
// Shared types, widths and register indexes for the button chord hold detector.
package bchd_pkg;

    localparam int NUM_CHORDS_DEFAULT = 4;
    localparam int MASK_W             = 4;
    localparam int ACTION_W           = 8;
    localparam int HOLD_W             = 16;
    localparam int TIME_W             = 48;
    localparam int COUNT_W            = 3;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 29;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_CHORDS_IN_USE = CFG_INDEX_W'(0);
    localparam int                     REG_CHORD_BASE    = 1;

    typedef struct packed {
        logic [HOLD_W-1:0]   hold_ms;
        logic [ACTION_W-1:0] action;
        logic                allow_rec;
        logic [MASK_W-1:0]   mask;
    } chord_word_t;

    typedef struct packed {
        logic              left_up_pressed;
        logic              left_down_pressed;
        logic              right_up_pressed;
        logic              right_down_pressed;
        logic              recording_on;
        logic [TIME_W-1:0] now_ms;
    } snapshot_t;

endpackage

// ----- design/bchd_ifs.sv -----
// Handshake channels of the button chord hold detector: snapshots, results, configuration.
interface bchd_in_if;
    import bchd_pkg::*;

    logic              valid;
    logic              ready;
    logic              left_up_pressed;
    logic              left_down_pressed;
    logic              right_up_pressed;
    logic              right_down_pressed;
    logic              recording_on;
    logic [TIME_W-1:0] now_ms;

    modport source (
        output valid, left_up_pressed, left_down_pressed, right_up_pressed,
               right_down_pressed, recording_on, now_ms,
        input  ready
    );
    modport sink (
        input  valid, left_up_pressed, left_down_pressed, right_up_pressed,
               right_down_pressed, recording_on, now_ms,
        output ready
    );
endinterface

interface bchd_out_if;
    import bchd_pkg::*;

    logic                valid;
    logic                ready;
    logic [MASK_W-1:0]   claimed_mask;
    logic                action_valid;
    logic [ACTION_W-1:0] action_code;

    modport source (
        output valid, claimed_mask, action_valid, action_code,
        input  ready
    );
    modport sink (
        input  valid, claimed_mask, action_valid, action_code,
        output ready
    );
endinterface

interface bchd_cfg_if;
    import bchd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- design/button_chord_hold_detector_core.sv -----
// Button chord hold detector: one input register, single-pass chord match, result register.
//
// Usage:
//   snapshot : one word per button sample (four buttons, recording flag, ms timestamp).
//   result   : one word per snapshot (claimed mask, action valid, action code).
//   cfg      : register writes, always ready; index 0 is the chord count, indexes 1..4
//              hold the chord definitions. Write only while the block is idle.
// An accepted snapshot is held in the input register; its result is written to the result register.
//   Throughput: one snapshot per cycle while the result side does not stall, set by the chord
//   state update, which reads and writes the per-chord hold timers.
// The input register and the result register part the two sides: a snapshot is taken
//   while a finished result waits. When the receiver stalls, the result holds, the input
//   register fills, and snapshot.ready drops until the result is taken.
// Reset clears the chord count, all chord definitions, the hold timers, the fired
//   flags and the release latch; both registers come out of reset empty.
module button_chord_hold_detector_core #(
    parameter int NUM_CHORDS = bchd_pkg::NUM_CHORDS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    bchd_in_if.sink       snapshot,
    bchd_out_if.source    result,
    bchd_cfg_if.sink      cfg
);
    import bchd_pkg::*;

    // Configuration
    logic [COUNT_W-1:0] chords_in_use_reg;
    chord_word_t        chord_word_reg [NUM_CHORDS];

    // Chord state
    logic [MASK_W-1:0]     latch_reg, latch_next;
    logic [NUM_CHORDS-1:0] active_reg, active_next;
    logic [NUM_CHORDS-1:0] fired_reg, fired_next;
    logic [TIME_W-1:0]     since_reg [NUM_CHORDS];
    logic [TIME_W-1:0]     since_next [NUM_CHORDS];

    // Input register
    logic      in_valid_reg;
    snapshot_t in_reg;

    // Result register
    logic                out_valid_reg;
    logic [MASK_W-1:0]   consumed_reg, consumed_next;
    logic                action_valid_reg, action_valid_next;
    logic [ACTION_W-1:0] action_code_reg, action_code_next;

    logic proc_fire;

    assign proc_fire     = in_valid_reg && (!out_valid_reg || result.ready);
    assign snapshot.ready = !in_valid_reg || proc_fire;
    assign cfg.ready      = 1'b1;

    // Configuration writes; indexes past the last chord are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chords_in_use_reg <= '0;
            for (int k = 0; k < NUM_CHORDS; k++)
            begin
                chord_word_reg[k] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_CHORDS_IN_USE)
            begin
                chords_in_use_reg <= cfg.data[COUNT_W-1:0];
            end
            for (int k = 0; k < NUM_CHORDS; k++)
            begin
                if (cfg.index == CFG_INDEX_W'(REG_CHORD_BASE + k))
                begin
                    chord_word_reg[k] <= chord_word_t'(cfg.data);
                end
            end
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (snapshot.ready)
        begin
            in_valid_reg <= snapshot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snapshot.valid && snapshot.ready)
        begin
            in_reg.left_up_pressed    <= snapshot.left_up_pressed;
            in_reg.left_down_pressed  <= snapshot.left_down_pressed;
            in_reg.right_up_pressed   <= snapshot.right_up_pressed;
            in_reg.right_down_pressed <= snapshot.right_down_pressed;
            in_reg.recording_on       <= snapshot.recording_on;
            in_reg.now_ms             <= snapshot.now_ms;
        end
    end

    // Chord match and state update
    always_comb
    begin
        logic [MASK_W-1:0]     pressed;
        logic                  latched;
        logic [NUM_CHORDS-1:0] hit;
        logic [NUM_CHORDS-1:0] sel;
        logic                  lower_hit;
        logic                  hit_any;
        chord_word_t           sel_word;
        logic                  sel_active;
        logic                  sel_fired;
        logic [TIME_W-1:0]     sel_since;
        logic [TIME_W-1:0]     since_eff;
        logic [TIME_W-1:0]     held;
        logic                  fire;

        pressed = {in_reg.right_down_pressed, in_reg.right_up_pressed,
                   in_reg.left_down_pressed, in_reg.left_up_pressed};
        latched = (latch_reg != '0);

        // Chords at or past the count never match, which also saturates the count
        for (int k = 0; k < NUM_CHORDS; k++)
        begin
            hit[k] = (int'(chords_in_use_reg) > k)
                  && (!in_reg.recording_on || chord_word_reg[k].allow_rec)
                  && (pressed == chord_word_reg[k].mask);
        end

        // Lowest matching chord wins
        lower_hit = 1'b0;
        for (int k = 0; k < NUM_CHORDS; k++)
        begin
            sel[k]    = hit[k] && !lower_hit;
            lower_hit = lower_hit || hit[k];
        end
        hit_any = lower_hit;

        sel_word   = '0;
        sel_active = 1'b0;
        sel_fired  = 1'b0;
        sel_since  = '0;
        for (int k = 0; k < NUM_CHORDS; k++)
        begin
            sel_word   = sel_word | (chord_word_reg[k] & {$bits(chord_word_t){sel[k]}});
            sel_active = sel_active | (active_reg[k] & sel[k]);
            sel_fired  = sel_fired | (fired_reg[k] & sel[k]);
            sel_since  = sel_since | (since_reg[k] & {TIME_W{sel[k]}});
        end

        // A fresh hold starts now; time running backwards counts as no hold
        since_eff = sel_active ? sel_since : in_reg.now_ms;
        held      = (in_reg.now_ms >= since_eff) ? (in_reg.now_ms - since_eff) : '0;
        fire      = hit_any && !sel_fired && (held >= TIME_W'(sel_word.hold_ms));

        active_next = active_reg;
        fired_next  = fired_reg;
        for (int k = 0; k < NUM_CHORDS; k++)
        begin
            since_next[k] = since_reg[k];
        end
        latch_next        = latch_reg;
        consumed_next     = '0;
        action_valid_next = 1'b0;
        action_code_next  = '0;

        if (latched)
        begin
            // Hold chord state; drop the latch once its buttons are all up
            if ((pressed & latch_reg) == '0)
            begin
                latch_next = '0;
            end
            else
            begin
                consumed_next = latch_reg;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_CHORDS; k++)
            begin
                active_next[k] = sel[k];
                fired_next[k]  = sel[k] && (fired_reg[k] || fire);
                since_next[k]  = sel[k] ? since_eff : '0;
            end
            if (hit_any)
            begin
                consumed_next = sel_word.mask;
            end
            if (fire)
            begin
                action_valid_next = 1'b1;
                action_code_next  = sel_word.action;
                latch_next        = sel_word.mask;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg  <= '0;
            active_reg <= '0;
            fired_reg  <= '0;
            for (int k = 0; k < NUM_CHORDS; k++)
            begin
                since_reg[k] <= '0;
            end
        end
        else if (proc_fire)
        begin
            latch_reg  <= latch_next;
            active_reg <= active_next;
            fired_reg  <= fired_next;
            for (int k = 0; k < NUM_CHORDS; k++)
            begin
                since_reg[k] <= since_next[k];
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            consumed_reg     <= consumed_next;
            action_valid_reg <= action_valid_next;
            action_code_reg  <= action_code_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.claimed_mask = consumed_reg;
    assign result.action_valid = action_valid_reg;
    assign result.action_code  = action_code_reg;

endmodule

// ----- tb/button_chord_hold_detector_core_checker.sv -----
`timescale 1ns / 100ps
// Watches the detector's channels, predicts each result word and compares it with the block.
module button_chord_hold_detector_core_checker
    import bchd_pkg::*;
#(
    parameter int NUM_CHORDS = NUM_CHORDS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    bchd_in_if   snapshot,
    bchd_out_if  result,
    bchd_cfg_if  cfg,
    output int   errors,
    output int   pending
);

    localparam int CHORD_SLOTS = 4;

    typedef struct packed {
        logic [MASK_W-1:0]   claimed_mask;
        logic                action_valid;
        logic [ACTION_W-1:0] action_code;
    } chord_result_t;

    logic [COUNT_W-1:0] chord_count;
    chord_word_t        chord_def [CHORD_SLOTS];
    logic [MASK_W-1:0]  release_mask;
    logic               timer_running [CHORD_SLOTS];
    logic               already_fired [CHORD_SLOTS];
    logic [TIME_W-1:0]  hold_start [CHORD_SLOTS];
    chord_result_t      expected_results [$];

    function automatic chord_result_t predict_chords(input logic [MASK_W-1:0] pressed,
                                                     input logic recording,
                                                     input logic [TIME_W-1:0] stamp);
        chord_result_t     res;
        int                used;
        int                hit;
        logic [TIME_W-1:0] held;
        res  = '0;
        used = (int'(chord_count) > NUM_CHORDS) ? NUM_CHORDS : int'(chord_count);
        hit  = -1;
        // latched: report the latch until every latched button is let go, touch no timer
        if (release_mask != '0) begin
            if ((pressed & release_mask) == '0)
                release_mask = '0;
            else
                res.claimed_mask = release_mask;
            return res;
        end
        for (int k = 0; k < CHORD_SLOTS; k++) begin
            if (hit < 0 && k < used && (!recording || chord_def[k].allow_rec)
                    && pressed == chord_def[k].mask)
                hit = k;
        end
        for (int k = 0; k < CHORD_SLOTS; k++) begin
            if (k != hit) begin
                timer_running[k] = 1'b0;
                already_fired[k] = 1'b0;
                hold_start[k]    = '0;
            end
        end
        if (hit >= 0) begin
            res.claimed_mask = chord_def[hit].mask;
            if (!timer_running[hit]) begin
                timer_running[hit] = 1'b1;
                hold_start[hit]    = stamp;
            end
            // a stamp earlier than the start counts as no hold at all
            held = (stamp >= hold_start[hit]) ? stamp - hold_start[hit] : '0;
            if (!already_fired[hit] && held >= TIME_W'(chord_def[hit].hold_ms)) begin
                already_fired[hit] = 1'b1;
                res.action_valid   = 1'b1;
                res.action_code    = chord_def[hit].action;
                release_mask       = chord_def[hit].mask;
            end
        end
        return res;
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        chord_result_t want;
        if (!rst_n) begin
            chord_count  = '0;
            release_mask = '0;
            for (int k = 0; k < CHORD_SLOTS; k++) begin
                chord_def[k]     = '0;
                timer_running[k] = 1'b0;
                already_fired[k] = 1'b0;
                hold_start[k]    = '0;
            end
            expected_results.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_CHORDS_IN_USE)
                    chord_count = cfg.data[COUNT_W-1:0];
                else if (int'(cfg.index) >= REG_CHORD_BASE
                         && int'(cfg.index) < REG_CHORD_BASE + CHORD_SLOTS)
                    chord_def[int'(cfg.index) - REG_CHORD_BASE] = cfg.data;
            end
            if (snapshot.valid && snapshot.ready)
                expected_results.insert(expected_results.size(), predict_chords(
                    {snapshot.right_down_pressed, snapshot.right_up_pressed,
                     snapshot.left_down_pressed, snapshot.left_up_pressed},
                    snapshot.recording_on, snapshot.now_ms));
            if (result.valid && result.ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result word with no snapshot pending, actual %0d/%0d/%0d",
                             $time, result.claimed_mask, result.action_valid,
                             result.action_code);
                end else begin
                    want = expected_results.pop_front();
                    if (result.claimed_mask !== want.claimed_mask)
                        report_field("claimed_mask", int'(want.claimed_mask),
                                     int'(result.claimed_mask));
                    if (result.action_valid !== want.action_valid)
                        report_field("action_valid", int'(want.action_valid),
                                     int'(result.action_valid));
                    if (result.action_code !== want.action_code)
                        report_field("action_code", int'(want.action_code),
                                     int'(result.action_code));
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- tb/button_chord_hold_detector_core_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives snapshots and chord settings, stalls the result side, gives the verdict.
module button_chord_hold_detector_core_tb;
    import bchd_pkg::*;

    localparam int NUM_CHORDS   = 4;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int RANDOM_PHASES = 9;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycle_count;
    int   sent;
    int   stall_left;
    logic calm;

    logic [COUNT_W-1:0] chord_count;
    chord_word_t        chord_set [4];
    logic [TIME_W-1:0]  clock_ms;

    bchd_in_if  snapshot_ch ();
    bchd_out_if result_ch ();
    bchd_cfg_if cfg_ch ();

    button_chord_hold_detector_core #(
        .NUM_CHORDS (NUM_CHORDS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .snapshot (snapshot_ch),
        .result   (result_ch),
        .cfg      (cfg_ch)
    );

    button_chord_hold_detector_core_checker #(
        .NUM_CHORDS (NUM_CHORDS)
    ) i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .snapshot (snapshot_ch),
        .result   (result_ch),
        .cfg      (cfg_ch),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none at all while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // result side: take words with random stalls
    initial
    begin
        result_ch.ready = 1'b0;
        stall_left      = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // enter and leave at a falling edge; valid stays high for the next word
    task automatic send_snapshot(input logic [MASK_W-1:0] buttons, input logic recording,
                                 input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            snapshot_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        snapshot_ch.valid              = 1'b1;
        snapshot_ch.left_up_pressed    = buttons[0];
        snapshot_ch.left_down_pressed  = buttons[1];
        snapshot_ch.right_up_pressed   = buttons[2];
        snapshot_ch.right_down_pressed = buttons[3];
        snapshot_ch.recording_on       = recording;
        snapshot_ch.now_ms             = stamp;
        do @(posedge clk); while (!snapshot_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_idle();
        snapshot_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    // drain, then load the chord count and all four chord words
    task automatic load_chords();
        wait_idle();
        write_reg(REG_CHORDS_IN_USE, CFG_DATA_W'(chord_count));
        for (int k = 0; k < 4; k++)
            write_reg(CFG_INDEX_W'(REG_CHORD_BASE + k), CFG_DATA_W'(chord_set[k]));
        cfg_ch.valid = 1'b0;
    endtask

    task automatic shuffle_chords(input int phase);
        int r;
        case (phase)
            0:       chord_count = 3'd4;
            1:       chord_count = 3'd7;
            2:       chord_count = 3'd0;
            default: chord_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                               : 3'($urandom_range(1, 4));
        endcase
        for (int k = 0; k < 4; k++)
        begin
            chord_set[k].mask      = 4'($urandom_range(0, 15));
            // share a mask with an earlier chord now and then to exercise priority
            if (k > 0 && $urandom_range(0, 3) == 0)
                chord_set[k].mask = chord_set[$urandom_range(0, k - 1)].mask;
            chord_set[k].allow_rec = 1'($urandom_range(0, 1));
            chord_set[k].action    = 8'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 70)
                chord_set[k].hold_ms = 16'($urandom_range(0, 6));
            else if (r < 90)
                chord_set[k].hold_ms = 16'($urandom_range(0, 40));
            else
                chord_set[k].hold_ms = 16'($urandom_range(0, 65535));
        end
    endtask

    function automatic logic [TIME_W-1:0] advance_clock(input logic [TIME_W-1:0] stamp);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return stamp + TIME_W'($urandom_range(0, 70000));
        if (r == 1)
            return stamp - TIME_W'($urandom_range(1, 50));
        return stamp + TIME_W'($urandom_range(0, 4));
    endfunction

    // press one chord for a while, then let go
    task automatic chord_press();
        int   k;
        int   len;
        logic recording;
        k         = $urandom_range(0, 3);
        len       = $urandom_range(1, 12);
        recording = chord_set[k].allow_rec ? 1'($urandom_range(0, 1))
                                           : ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
        begin
            clock_ms = advance_clock(clock_ms);
            send_snapshot(chord_set[k].mask, recording, clock_ms);
        end
        clock_ms = advance_clock(clock_ms);
        if ($urandom_range(0, 1) == 0)
            send_snapshot('0, recording, clock_ms);
        else
            send_snapshot(4'($urandom_range(0, 15)), recording, clock_ms);
    endtask

    task automatic stray_snapshot();
        if ($urandom_range(0, 19) == 0)
            clock_ms = {16'($urandom), 32'($urandom)};
        else
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 3));
        send_snapshot(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), clock_ms);
    endtask

    initial
    begin
        int target;
        cycle_count = 0;
        sent        = 0;
        calm        = 1'b0;
        clock_ms    = '0;
        rst_n       = 1'b0;
        snapshot_ch.valid              = 1'b0;
        snapshot_ch.left_up_pressed    = 1'b0;
        snapshot_ch.left_down_pressed  = 1'b0;
        snapshot_ch.right_up_pressed   = 1'b0;
        snapshot_ch.right_down_pressed = 1'b0;
        snapshot_ch.recording_on       = 1'b0;
        snapshot_ch.now_ms             = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_CHORDS_IN_USE;
        cfg_ch.data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // no chords in use after reset: nothing matches
        send_snapshot(4'b1111, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_snapshot(4'b0000, 1'b0, 48'h0);

        // chord zero shadows chord one except while recording; chord two has an empty mask
        chord_count  = 3'd4;
        chord_set[0] = '{hold_ms: 16'd5,     action: 8'h01, allow_rec: 1'b0, mask: 4'b0011};
        chord_set[1] = '{hold_ms: 16'd0,     action: 8'hA5, allow_rec: 1'b1, mask: 4'b0011};
        chord_set[2] = '{hold_ms: 16'd10,    action: 8'h80, allow_rec: 1'b1, mask: 4'b0000};
        chord_set[3] = '{hold_ms: 16'hFFFF,  action: 8'hFF, allow_rec: 1'b1, mask: 4'b1111};
        load_chords();
        send_snapshot(4'b0011, 1'b0, 48'd100);
        send_snapshot(4'b0011, 1'b0, 48'd103);
        send_snapshot(4'b0011, 1'b0, 48'd105);
        send_snapshot(4'b0001, 1'b0, 48'd106);
        send_snapshot(4'b0100, 1'b0, 48'd107);
        send_snapshot(4'b0000, 1'b1, 48'd108);
        send_snapshot(4'b0000, 1'b1, 48'd50);
        send_snapshot(4'b0000, 1'b1, 48'd118);
        send_snapshot(4'b0000, 1'b0, 48'd200);
        send_snapshot(4'b0011, 1'b1, 48'd300);
        send_snapshot(4'b0000, 1'b1, 48'd301);
        send_snapshot(4'b1111, 1'b0, 48'd302);
        send_snapshot(4'b1111, 1'b0, 48'd65836);
        send_snapshot(4'b1111, 1'b0, 48'd65837);
        send_snapshot(4'b1110, 1'b0, 48'd65900);
        send_snapshot(4'b0000, 1'b0, 48'd65901);
        send_snapshot(4'b1111, 1'b1, 48'hFFFF_FFFF_FFFF);
        send_snapshot(4'b1111, 1'b1, 48'h0);
        send_snapshot(4'b0101, 1'b1, 48'd1);

        // count above the chord total saturates; a count of one leaves the rest out
        chord_count = 3'd7;
        load_chords();
        send_snapshot(4'b1111, 1'b0, 48'd10);
        send_snapshot(4'b0011, 1'b0, 48'd20);
        chord_count = 3'd1;
        load_chords();
        send_snapshot(4'b1111, 1'b0, 48'd30);
        send_snapshot(4'b0011, 1'b1, 48'd40);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            shuffle_chords(phase);
            load_chords();
            calm   = (phase % 3 == 2);
            target = sent + PHASE_ITEMS;
            while (sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    chord_press();
                else
                    stray_snapshot();
            end
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
